// ----- sv/first_fit_interval_reservation_macros.svh -----
// Assertion macros used by the reservation block's datapath.
`ifndef FIRST_FIT_INTERVAL_RESERVATION_MACROS_SVH
`define FIRST_FIT_INTERVAL_RESERVATION_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define FFIR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define FFIR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define FFIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ffir_pkg.sv -----
// Types and constants shared by the first-fit reservation block.
`timescale 1ns / 1ps
package ffir_pkg;

  localparam int NUM_RESOURCES_DEF = 4;
  localparam int MAX_BOOKINGS_DEF  = 16;

  localparam int DAY_W  = 10;
  localparam int TIME_W = 11;
  localparam int CFG_W  = 3;
  localparam int IDX_W  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

  // Request layout doubles as the stored booking word: day, start, end.
  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] resource_index;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_req;
    logic res_next;
    logic scan_start;
    logic scan_issue;
    logic commit;
    logic granted;
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic res_end;
    logic res_full;
    logic scan_more;
    logic hit;
    logic out_free;
  } ctl_stat_t;

endpackage

// ----- sv/ffir_ctrl.sv -----
// Sequencer that walks the resources and their bookings for one request.
`timescale 1ns / 1ps
module ffir_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ffir_pkg::ctl_stat_t stat,
  output ffir_pkg::ctl_cmd_t  cmd
);
  import ffir_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    PICK,
    SCAN,
    COMMIT
  } state_t;

  state_t state;
  logic   grant;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      grant <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (req_valid) begin
            state <= PICK;
          end
        end
        PICK: begin
          if (stat.res_end) begin
            grant <= 1'b0;
            state <= COMMIT;
          end else if (!stat.res_full) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (stat.hit) begin
            state <= PICK;
          end else if (!stat.scan_more) begin
            grant <= 1'b1;
            state <= COMMIT;
          end
        end
        COMMIT: begin
          if (stat.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.granted    = grant;
    req_ready      = (state == IDLE);
    case (state)
      IDLE:   cmd.load_req = req_valid;
      PICK: begin
        cmd.res_next   = !stat.res_end && stat.res_full;
        cmd.scan_start = !stat.res_end && !stat.res_full;
      end
      SCAN: begin
        cmd.res_next   = stat.hit;
        cmd.scan_issue = !stat.hit && stat.scan_more;
      end
      COMMIT: cmd.commit = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- sv/ffir_datapath.sv -----
// Resource setting, request register, booking store, counts, scan pointers and result register.
`timescale 1ns / 1ps
`include "first_fit_interval_reservation_macros.svh"
module ffir_datapath #(
  parameter int NUM_RESOURCES = ffir_pkg::NUM_RESOURCES_DEF,
  parameter int MAX_BOOKINGS  = ffir_pkg::MAX_BOOKINGS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [ffir_pkg::CFG_W-1:0]   cfg_data,
  input  ffir_pkg::req_t               req_data,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output ffir_pkg::rsp_t               rsp_data,
  input  ffir_pkg::ctl_cmd_t           cmd,
  output ffir_pkg::ctl_stat_t          stat
);
  import ffir_pkg::*;

  localparam int DEPTH  = NUM_RESOURCES * MAX_BOOKINGS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RCW    = $clog2(NUM_RESOURCES + 1);
  localparam int RIW    = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int CNW    = $clog2(MAX_BOOKINGS + 1);
  localparam int BIW    = (MAX_BOOKINGS > 1) ? $clog2(MAX_BOOKINGS) : 1;
  localparam int CMPW   = (RCW > CFG_W) ? RCW : CFG_W;

  logic [CFG_W-1:0] resources_in_use;
  req_t             req;
  logic [RCW-1:0]   res;
  logic [CNW-1:0]   entry;
  logic [CNW-1:0]   booking_count [NUM_RESOURCES];
  req_t             booking_store [DEPTH];
  req_t             rd_data;
  logic             rd_valid;

  logic [RIW-1:0]   res_idx;
  logic [CNW-1:0]   cur_count;
  logic [AW-1:0]    base_addr;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             overlap;
  logic             wr_grant;

  assign res_idx   = res[RIW-1:0];
  assign cur_count = booking_count[res_idx];
  assign base_addr = AW'(res_idx) * AW'(MAX_BOOKINGS);
  assign rd_addr   = base_addr + AW'(entry[BIW-1:0]);
  assign wr_addr   = base_addr + AW'(cur_count[BIW-1:0]);
  assign wr_grant  = cmd.commit && cmd.granted;

  assign overlap = (rd_data.day == req.day) &&
                   (rd_data.start_time < req.end_time) &&
                   (req.start_time < rd_data.end_time);

  always_comb begin
    stat.res_end   = (CMPW'(res) >= CMPW'(resources_in_use)) ||
                     (res >= RCW'(NUM_RESOURCES));
    stat.res_full  = (cur_count == CNW'(MAX_BOOKINGS));
    stat.scan_more = (entry < cur_count);
    stat.hit       = rd_valid && overlap;
    stat.out_free  = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resources_in_use <= CFG_RESET;
    end else if (cfg_valid) begin
      resources_in_use <= cfg_data;
    end
  end

  // Scan pointers and the request being served.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= req_data;
      res <= '0;
    end else if (cmd.res_next) begin
      res <= res + RCW'(1);
    end
    if (cmd.scan_start) begin
      entry <= '0;
    end else if (cmd.scan_issue) begin
      entry <= entry + CNW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_issue;
    end
  end

  // Booking store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_grant) begin
      booking_store[wr_addr] <= req;
    end
    if (cmd.scan_issue) begin
      rd_data <= booking_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_RESOURCES; k++) begin
        booking_count[k] <= '0;
      end
    end else if (wr_grant) begin
      booking_count[res_idx] <= cur_count + CNW'(1);
    end
  end

  // Result register; hold until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_data.granted        <= cmd.granted;
      rsp_data.resource_index <= cmd.granted ? IDX_W'(res) : '0;
    end
  end

  `FFIR_ASSERT_IMPL(a_grant_has_room, wr_grant, !stat.res_end && !stat.res_full, "grant without room")
  `FFIR_ASSERT_IMPL(a_issue_in_range, cmd.scan_issue, stat.scan_more && !stat.res_end, "read past count")
  `FFIR_ASSERT_IMPL(a_commit_slot_free, cmd.commit, stat.out_free, "result overwritten")
  `FFIR_ASSERT_NEXT(a_count_advances, wr_grant, rsp_valid && rsp_data.granted, "grant not reported")

endmodule

// ----- sv/first_fit_interval_reservation.sv -----
// Operation: per resource offered, PICK skips it if full, else SCAN reads its bookings from
// the store (one booking read per cycle) until a clash or the last one; then COMMIT.
// Throughput: one request at a time; the next is taken once the result is registered.
// Set by the single read port of the booking store walked one entry per cycle.
// Reset (rst, synchronous): booking counts zero, resources_in_use = 3, no result pending.
`timescale 1ns / 1ps
module first_fit_interval_reservation #(
  parameter int NUM_RESOURCES = ffir_pkg::NUM_RESOURCES_DEF,
  parameter int MAX_BOOKINGS  = ffir_pkg::MAX_BOOKINGS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ffir_pkg::CFG_W-1:0] cfg_data,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  ffir_pkg::req_t             req_data,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output ffir_pkg::rsp_t             rsp_data
);
  import ffir_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  assign cfg_ready = 1'b1;

  ffir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffir_datapath #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .MAX_BOOKINGS  (MAX_BOOKINGS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- tb/first_fit_interval_reservation_tb.sv -----
// Self-checking testbench for the first-fit interval reservation block.
`timescale 1ns / 1ps
module first_fit_interval_reservation_tb;
  import ffir_pkg::*;

  localparam int NUM_RES        = NUM_RESOURCES_DEF;
  localparam int MAX_BOOK       = MAX_BOOKINGS_DEF;
  localparam int TIME_MAX       = (1 << TIME_W) - 1;
  localparam int DRAIN_CYCLES   = NUM_RES * (MAX_BOOK + 2) + 3;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int QUIET_LIMIT    = 4000;
  localparam int PHASES         = 7;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req_data = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp_data;

  // Shadow copy of the block's bookings and setting
  req_t             bookings [NUM_RES][MAX_BOOK];
  int unsigned      booked_count [NUM_RES];
  logic [CFG_W-1:0] resources_offered;

  req_t request_q [$];
  rsp_t grant_q [$];

  logic [DAY_W-1:0] hot_days [4] = '{10'd0, 10'd1023, 10'd17, 10'd600};
  int unsigned      phase_setting [PHASES] = '{0, 1, 7, 2, 4, 5, 1};
  int unsigned      phase_items [PHASES]   = '{60, 100, 100, 90, 100, 90, 90};

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned results_seen = 0;
  int unsigned holdoff_left = 0;
  int unsigned pattern_age = 0;
  logic        stalling = 1'b0;
  logic [15:0] stall_pat = 16'hffff;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  rsp_t        want;

  first_fit_interval_reservation u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer the request to each resource in turn; the first with room and no clash keeps it.
  function automatic rsp_t reserve_first_fit(req_t r);
    rsp_t        res;
    int unsigned limit;
    logic        clash;
    res = '0;
    limit = (resources_offered > NUM_RES) ? NUM_RES : resources_offered;
    for (int k = 0; k < limit; k++) begin
      if (booked_count[k] < MAX_BOOK) begin
        clash = 1'b0;
        for (int j = 0; j < booked_count[k]; j++) begin
          if (bookings[k][j].day == r.day && bookings[k][j].start_time < r.end_time &&
              r.start_time < bookings[k][j].end_time)
            clash = 1'b1;
        end
        if (!clash) begin
          bookings[k][booked_count[k]] = r;
          booked_count[k]++;
          res.granted = 1'b1;
          res.resource_index = k[IDX_W-1:0];
          return res;
        end
      end
    end
    return res;
  endfunction

  function automatic req_t booking_req(int unsigned d, int unsigned s, int unsigned e);
    req_t r;
    r.day = d[DAY_W-1:0];
    r.start_time = s[TIME_W-1:0];
    r.end_time = e[TIME_W-1:0];
    return r;
  endfunction

  task automatic add_request(input req_t r);
    request_q = {request_q, r};
  endtask

  // Mostly contended intervals on a few busy days, some inverted, some fully random.
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    r = $urandom;
    if (pick < 60) begin
      r.day = hot_days[2'($urandom_range(0, 3))];
      r.start_time = TIME_W'($urandom_range(0, 1900));
      len = $urandom_range(1, 400);
      r.end_time = TIME_W'((r.start_time + len > TIME_MAX) ? TIME_MAX : r.start_time + len);
    end else if (pick < 75) begin
      if (pick < 68)
        r.day = hot_days[2'($urandom_range(0, 3))];
      r.end_time = TIME_W'($urandom_range(0, r.start_time));
    end
    return r;
  endfunction

  task automatic wait_idle();
    do @(negedge clk); while (request_q.size() != 0 || req_valid || grant_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_resources(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    resources_offered = value;
  endtask

  // Request driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (req_valid && req_ready)
        grant_q = {grant_q, reserve_first_fit(req_data)};
      if (!req_valid || req_ready) begin
        if (gap_left != 0 || request_q.size() == 0) begin
          req_valid <= 1'b0;
          if (gap_left != 0)
            gap_left <= gap_left - 1;
        end else begin
          req_valid <= 1'b1;
          req_data <= request_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        results_seen = results_seen + 1;
        if (grant_q.size() == 0) begin
          $display("%0t: result with none expected: granted=%0b index=%0d",
                   $time, rsp_data.granted, rsp_data.resource_index);
          errors++;
        end else begin
          want = grant_q.pop_front();
          if (want.granted !== rsp_data.granted) begin
            $display("%0t: granted expected %0b actual %0b",
                     $time, want.granted, rsp_data.granted);
            errors++;
          end
          if (want.resource_index !== rsp_data.resource_index) begin
            $display("%0t: resource_index expected %0d actual %0d",
                     $time, want.resource_index, rsp_data.resource_index);
            errors++;
          end
        end
      end
      // Hold off for a long stretch twice so the block backs up into the sender
      if (holdoff_left != 0) begin
        holdoff_left = holdoff_left - 1;
        rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready && (results_seen == 30 || results_seen == 350)) begin
        holdoff_left = HOLDOFF_CYCLES;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= stalling ? stall_pat[0] : 1'b1;
      end
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      if (pattern_age == 0) begin
        stalling = ($urandom_range(0, 2) != 0);
        stall_pat = 16'($urandom | 1);
        pattern_age = $urandom_range(16, 96);
      end else begin
        pattern_age = pattern_age - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    for (int k = 0; k < NUM_RES; k++)
      booked_count[k] = 0;
    resources_offered = CFG_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Directed part under the reset setting of three resources
    add_request(booking_req(0, 0, 2047));
    add_request(booking_req(0, 0, 2047));
    add_request(booking_req(0, 0, 2047));
    add_request(booking_req(0, 0, 2047));
    add_request(booking_req(1023, 2047, 2047));
    add_request(booking_req(1023, 100, 200));
    add_request(booking_req(1023, 150, 160));
    add_request(booking_req(1023, 200, 300));
    add_request(booking_req(1023, 99, 100));
    add_request(booking_req(1023, 500, 50));
    add_request(booking_req(1023, 10, 60));
    add_request(booking_req(1023, 600, 700));
    add_request(booking_req(1023, 0, 2047));
    add_request(booking_req(1023, 0, 2047));
    add_request(booking_req(512, 1024, 1024));
    add_request(booking_req(341, 1365, 682));
    add_request(booking_req(682, 682, 1365));
    add_request(booking_req(0, 2046, 2047));
    add_request(booking_req(0, 2047, 0));
    wait_idle();
    for (int p = 0; p < PHASES; p++) begin
      write_resources(phase_setting[p][CFG_W-1:0]);
      @(negedge clk);
      repeat (phase_items[p]) add_request(random_request());
      wait_idle();
    end
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- first_fit_interval_reservation.f -----
+incdir+sv
sv/ffir_pkg.sv
sv/ffir_ctrl.sv
sv/ffir_datapath.sv
sv/first_fit_interval_reservation.sv
tb/first_fit_interval_reservation_tb.sv
